// File: rtl/core/hbf_pkg.sv
// Package for the header bit field access block.
// Holds the shared widths, command codes and the request record; no dependencies.
package hbf_pkg;

    localparam int BUF_BYTES_DEF = 64;
    localparam int OFFSET_W      = 9;
    localparam int SIZE_W        = 6;
    localparam int DATA_W        = 32;
    localparam int WORD_W        = 32;
    localparam int POS_W         = 5;
    localparam int MAX_FIELD     = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic              err;
        logic              sec_ok;
        logic              swap;
        logic [POS_W-1:0]  pos;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] value;
    } req_t;

endpackage

// File: rtl/core/hbf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on no package.
module hbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/hbf_merge.sv
// Field extract and insert datapath over two adjacent 32-bit header words.
// Depends on hbf_pkg.
module hbf_merge (
    input  logic [hbf_pkg::WORD_W-1:0] first_word,
    input  logic [hbf_pkg::WORD_W-1:0] second_word,
    input  hbf_pkg::req_t              req,
    output logic [hbf_pkg::WORD_W-1:0] new_first,
    output logic [hbf_pkg::WORD_W-1:0] new_second,
    output logic [hbf_pkg::DATA_W-1:0] field
);

    logic [63:0] cat;
    logic [63:0] mask;
    logic [63:0] ext;
    logic [63:0] ins;
    logic [6:0]  sh;

    // Bit zero of the buffer is the most significant bit of the pair.
    always_comb
    begin
        cat  = {first_word, second_word};
        sh   = 7'd64 - {2'b00, req.pos} - {1'b0, req.size};
        mask = (64'd1 << req.size) - 64'd1;
        ext  = (cat >> sh) & mask;
        ins  = (cat & ~(mask << sh)) | ((64'(req.value) & mask) << sh);
    end

    assign field      = ext[hbf_pkg::DATA_W-1:0];
    assign new_first  = ins[63:32];
    assign new_second = ins[31:0];

endmodule

// File: rtl/core/header_bit_field_access.sv
// Top level of the header bit field access block.
// Depends on hbf_pkg, hbf_ram and hbf_merge.
//
// The header buffer is held as 32-bit words, big-endian by bit, split into an even and an odd
// word bank so that the two words a field can touch are read in the same cycle. After reset
// the block clears both banks, one row of each per cycle, and accepts no transaction during
// that pass. For each transaction the banks are read at the edge that accepts it, and the
// merge state then merges the field, writes the words back and loads the result register.
// A result waiting on out_stall holds the block in its merge cycle; the read-modify-write
// through the one bank read port sets the rate.
module header_bit_field_access #(
    parameter int BUF_BYTES = hbf_pkg::BUF_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [hbf_pkg::OFFSET_W-1:0]  bit_offset,
    input  logic [hbf_pkg::SIZE_W-1:0]    field_size,
    input  logic [hbf_pkg::DATA_W-1:0]    write_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hbf_pkg::DATA_W-1:0]    read_value,
    output logic                          range_error
);

    localparam int WORDS      = (BUF_BYTES + 3) / 4;
    localparam int ROWS       = (WORDS + 1) / 2;
    localparam int AW         = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TOTAL_BITS = BUF_BYTES * 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MERGE
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              clr_reg;
    hbf_pkg::req_t              req_reg;
    logic [AW-1:0]              even_row_reg;
    logic [AW-1:0]              odd_row_reg;
    logic                       out_valid_reg;
    logic [hbf_pkg::DATA_W-1:0] read_value_reg;
    logic                       range_error_reg;

    logic                       accept;
    logic                       finish;
    logic [3:0]                 word_idx;
    logic [4:0]                 even_row;
    logic [4:0]                 odd_row;
    logic                       err;
    hbf_pkg::req_t              req_next;
    logic                       write_ok;
    logic                       read_ok;
    logic                       we_even;
    logic                       we_odd;
    logic [AW-1:0]              even_waddr;
    logic [AW-1:0]              odd_waddr;
    logic [hbf_pkg::WORD_W-1:0] even_wdata;
    logic [hbf_pkg::WORD_W-1:0] odd_wdata;
    logic [hbf_pkg::WORD_W-1:0] even_rdata;
    logic [hbf_pkg::WORD_W-1:0] odd_rdata;
    logic [hbf_pkg::WORD_W-1:0] first_word;
    logic [hbf_pkg::WORD_W-1:0] second_word;
    logic [hbf_pkg::WORD_W-1:0] new_first;
    logic [hbf_pkg::WORD_W-1:0] new_second;
    logic [hbf_pkg::DATA_W-1:0] field;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign finish   = (state_reg == ST_MERGE) && !(out_valid_reg && out_stall);

    always_comb
    begin
        word_idx = bit_offset[hbf_pkg::OFFSET_W-1:hbf_pkg::POS_W];
        even_row = ({1'b0, word_idx} + 5'd1) >> 1;
        odd_row  = {1'b0, word_idx} >> 1;
        err      = (field_size != '0)
                   && ((32'(field_size) > 32'(hbf_pkg::MAX_FIELD))
                       || (32'(bit_offset) + 32'(field_size) > 32'(TOTAL_BITS)));
        req_next.cmd    = cmd;
        req_next.err    = err;
        req_next.sec_ok = (32'(word_idx) + 32'd1) < 32'(WORDS);
        req_next.swap   = word_idx[0];
        req_next.pos    = bit_offset[hbf_pkg::POS_W-1:0];
        req_next.size   = field_size;
        req_next.value  = write_value;
    end

    assign first_word  = req_reg.swap ? odd_rdata : even_rdata;
    assign second_word = req_reg.swap ? even_rdata : odd_rdata;

    hbf_merge u_merge (
        .first_word  (first_word),
        .second_word (second_word),
        .req         (req_reg),
        .new_first   (new_first),
        .new_second  (new_second),
        .field       (field)
    );

    always_comb
    begin
        write_ok = (req_reg.cmd == hbf_pkg::CMD_WRITE) && !req_reg.err
                   && (req_reg.size != '0);
        read_ok  = (req_reg.cmd == hbf_pkg::CMD_READ) && !req_reg.err
                   && (req_reg.size != '0);
        if (state_reg == ST_CLEAR)
        begin
            we_even    = 1'b1;
            we_odd     = 1'b1;
            even_waddr = clr_reg;
            odd_waddr  = clr_reg;
            even_wdata = '0;
            odd_wdata  = '0;
        end
        else
        begin
            we_even    = finish && write_ok && (!req_reg.swap || req_reg.sec_ok);
            we_odd     = finish && write_ok && (req_reg.swap || req_reg.sec_ok);
            even_waddr = even_row_reg;
            odd_waddr  = odd_row_reg;
            even_wdata = req_reg.swap ? new_second : new_first;
            odd_wdata  = req_reg.swap ? new_first : new_second;
        end
    end

    hbf_ram #(
        .WIDTH (hbf_pkg::WORD_W),
        .DEPTH (ROWS),
        .AW    (AW)
    ) u_even_bank (
        .clk   (clk),
        .we    (we_even),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .re    (accept),
        .raddr (AW'(even_row)),
        .rdata (even_rdata)
    );

    hbf_ram #(
        .WIDTH (hbf_pkg::WORD_W),
        .DEPTH (ROWS),
        .AW    (AW)
    ) u_odd_bank (
        .clk   (clk),
        .we    (we_odd),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .re    (accept),
        .raddr (AW'(odd_row)),
        .rdata (odd_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            req_reg         <= '0;
            even_row_reg    <= '0;
            odd_row_reg     <= '0;
            out_valid_reg   <= 1'b0;
            read_value_reg  <= '0;
            range_error_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !finish)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == 32'(ROWS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg      <= req_next;
                        even_row_reg <= AW'(even_row);
                        odd_row_reg  <= AW'(odd_row);
                        state_reg    <= ST_MERGE;
                    end
                end
                ST_MERGE:
                begin
                    if (finish)
                    begin
                        out_valid_reg   <= 1'b1;
                        read_value_reg  <= read_ok ? field : '0;
                        range_error_reg <= req_reg.err;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign range_error = range_error_reg;

`ifndef NO_ASSERTIONS
    a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_MERGE))
        else $error("result appeared without a merge cycle");

    a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> read_value == '0)
        else $error("rejected transaction returned a nonzero field");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !(we_even || we_odd))
        else $error("bank written while idle");

    a_accept_to_merge: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MERGE)
        else $error("accepted transaction did not enter the merge cycle");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for header_bit_field_access: bit field writes and reads against a
// byte image of the header buffer kept in the testbench. Depends on hbf_pkg and the block RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_W       = hbf_pkg::OFFSET_W;
    localparam int SIZE_W         = hbf_pkg::SIZE_W;
    localparam int DATA_W         = hbf_pkg::DATA_W;
    localparam int MAX_FIELD      = hbf_pkg::MAX_FIELD;
    localparam int BUF_BYTES      = hbf_pkg::BUF_BYTES_DEF;
    localparam int BUF_BITS       = 8 * BUF_BYTES;
    localparam int OFFSET_MAX     = (1 << OFFSET_W) - 1;
    localparam int SIZE_MAX       = (1 << SIZE_W) - 1;
    localparam int BIT_LAST       = 7;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int DRAIN_EVERY    = 311;
    localparam int TAIL_ITEMS     = 150;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                cmd;
        logic [OFFSET_W-1:0] bit_offset;
        logic [SIZE_W-1:0]   field_size;
        logic [DATA_W-1:0]   write_value;
    } field_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              range_error;
    } field_result_t;

    typedef struct packed {
        field_req_t req;
        logic       drain;
    } queued_item_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic                cmd         = hbf_pkg::CMD_WRITE;
    logic [OFFSET_W-1:0] bit_offset  = '0;
    logic [SIZE_W-1:0]   field_size  = '0;
    logic [DATA_W-1:0]   write_value = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [DATA_W-1:0]   read_value;
    logic                range_error;

    logic [7:0]          header_image [BUF_BYTES];
    queued_item_t        pending_items [$];
    field_result_t       expected_results [$];
    field_req_t          driven_req = '0;
    int unsigned         send_gap = 0;
    int unsigned         stall_left = 0;
    int unsigned         stuck_cycles = 0;
    int unsigned         cycle_count = 0;
    int unsigned         mismatches = 0;

    header_bit_field_access dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .bit_offset  (bit_offset),
        .field_size  (field_size),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .range_error (range_error)
    );

    function automatic field_result_t access_header(input field_req_t r);
        field_result_t res;
        int unsigned   field_end;
        int unsigned   bit_index;
        int unsigned   byte_index;
        int unsigned   bit_in_byte;
        res = '0;
        field_end = int'(r.bit_offset) + int'(r.field_size);
        if (r.field_size != 0)
        begin
            if (r.field_size > MAX_FIELD || field_end > BUF_BITS)
            begin
                res.range_error = 1'b1;
            end
            else
            begin
                for (int k = 0; k < int'(r.field_size); k++)
                begin
                    bit_index   = int'(r.bit_offset) + k;
                    byte_index  = bit_index >> 3;
                    bit_in_byte = BIT_LAST - (bit_index & BIT_LAST);
                    if (r.cmd == hbf_pkg::CMD_WRITE)
                        header_image[byte_index][bit_in_byte] =
                            r.write_value[int'(r.field_size) - 1 - k];
                    else
                        res.read_value[int'(r.field_size) - 1 - k] =
                            header_image[byte_index][bit_in_byte];
                end
            end
        end
        return res;
    endfunction

    function automatic bit idling_allowed();
        return pending_items.size() > TAIL_ITEMS && cycle_count[7:6] != 2'b00;
    endfunction

    task automatic queue_access(input logic op, input int unsigned off, input int unsigned size,
                                input logic [DATA_W-1:0] value);
        queued_item_t item;
        item.req.cmd         = op;
        item.req.bit_offset  = OFFSET_W'(off);
        item.req.field_size  = SIZE_W'(size);
        item.req.write_value = value;
        item.drain           = (pending_items.size() % DRAIN_EVERY) == DRAIN_EVERY - 1;
        pending_items.push_back(item);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        queued_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(access_header(driven_req));
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (pending_items[0].drain && expected_results.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    nxt = pending_items.pop_front();
                    driven_req  <= nxt.req;
                    cmd         <= nxt.req.cmd;
                    bit_offset  <= nxt.req.bit_offset;
                    field_size  <= nxt.req.field_size;
                    write_value <= nxt.req.write_value;
                    in_valid    <= 1'b1;
                    if (idling_allowed() && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 14);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idling_allowed() && $urandom_range(0, 9) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        field_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected transaction: read_value %h, range_error %b",
                       read_value, range_error);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_value !== want.read_value)
                begin
                    $error("read_value mismatch: expected %h, actual %h",
                           want.read_value, read_value);
                    mismatches++;
                end
                if (range_error !== want.range_error)
                begin
                    $error("range_error mismatch: expected %b, actual %b",
                           want.range_error, range_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        int unsigned pick;
        int unsigned size;
        int unsigned off;
        logic        op;
        rst_n = 1'b0;
        for (int i = 0; i < BUF_BYTES; i++)
            header_image[i] = '0;

        queue_access(hbf_pkg::CMD_WRITE, 0, 32, 32'hFFFF_FFFF);
        queue_access(hbf_pkg::CMD_READ, 0, 32, 32'h0);
        queue_access(hbf_pkg::CMD_WRITE, 480, 32, 32'hA5A5_5A5A);
        queue_access(hbf_pkg::CMD_READ, 480, 32, 32'hFFFF_FFFF);
        queue_access(hbf_pkg::CMD_READ, 481, 32, 32'h0);
        queue_access(hbf_pkg::CMD_WRITE, 511, 1, 32'h1);
        queue_access(hbf_pkg::CMD_READ, 511, 1, 32'h0);
        queue_access(hbf_pkg::CMD_WRITE, 511, 2, 32'h3);
        queue_access(hbf_pkg::CMD_READ, 511, 0, 32'h0);
        queue_access(hbf_pkg::CMD_WRITE, 300, 0, 32'hFFFF_FFFF);
        queue_access(hbf_pkg::CMD_READ, 0, 33, 32'h0);
        queue_access(hbf_pkg::CMD_WRITE, 0, SIZE_MAX, 32'hFFFF_FFFF);
        queue_access(hbf_pkg::CMD_READ, 500, SIZE_MAX, 32'h0);
        queue_access(hbf_pkg::CMD_WRITE, 27, 13, 32'h0000_1ABC);
        queue_access(hbf_pkg::CMD_READ, 27, 13, 32'h0);
        queue_access(hbf_pkg::CMD_READ, 24, 20, 32'h0);
        queue_access(hbf_pkg::CMD_WRITE, 5, 32, 32'h1234_5678);
        queue_access(hbf_pkg::CMD_READ, 5, 32, 32'h0);
        queue_access(hbf_pkg::CMD_READ, 0, 8, 32'h0);
        queue_access(hbf_pkg::CMD_WRITE, 64, 8, 32'h0);
        queue_access(hbf_pkg::CMD_READ, 56, 24, 32'h0);
        queue_access(hbf_pkg::CMD_WRITE, 100, 17, 32'hFFFF_0000);
        queue_access(hbf_pkg::CMD_READ, 96, 32, 32'h0);
        queue_access(hbf_pkg::CMD_READ, 511, 32, 32'h0);
        queue_access(hbf_pkg::CMD_READ, 0, 0, 32'h0);

        while (pending_items.size() < RANDOM_ITEMS + 25)
        begin
            pick = $urandom_range(0, 19);
            size = $urandom_range(1, MAX_FIELD);
            off  = $urandom_range(0, BUF_BITS - size);
            op   = 1'($urandom_range(0, 1));
            if (pick < 8)
            begin
                queue_access(hbf_pkg::CMD_WRITE, off, size, $urandom);
                queue_access(hbf_pkg::CMD_READ, off, size, $urandom);
            end
            else if (pick < 12)
            begin
                queue_access(op, off, size, $urandom);
            end
            else if (pick < 14)
            begin
                off = BUF_BITS - size + $urandom_range(0, 2);
                if (off > OFFSET_MAX)
                    off = OFFSET_MAX;
                queue_access(op, off, size, $urandom);
            end
            else if (pick < 15)
            begin
                queue_access(op, $urandom_range(0, OFFSET_MAX), 0, $urandom);
            end
            else if (pick < 16)
            begin
                queue_access(op, $urandom_range(0, OFFSET_MAX),
                             $urandom_range(MAX_FIELD + 1, SIZE_MAX), $urandom);
            end
            else
            begin
                queue_access(op, $urandom_range(0, OFFSET_MAX), $urandom_range(0, SIZE_MAX),
                             $urandom);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
